>>> sv/mcs_pkg.sv
// ----------------------------------------------------------------------------
// Motor command shaper package
// Shared payload types, lane and controller state encodings, and the
// fixed-point constants of the square-root shaper.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int THR_W      = 16;
    localparam int X_W        = 11;
    localparam int MOTOR_W    = 10;
    localparam int DIV_NUM_W  = 21;
    localparam int DIV_DEN_W  = 11;
    localparam int DIV_CNT_W  = 5;

    localparam logic [X_W-1:0]       THR_MIN     = 11'd63;
    localparam logic [X_W-1:0]       THR_MAX     = 11'd1024;
    localparam logic [20:0]          EST_C0      = 21'd1440768;
    localparam logic [9:0]           EST_C1      = 10'd588;
    localparam logic [20:0]          EST_C2      = 21'd179200;
    localparam logic [MOTOR_W-1:0]   ROOT_MIN    = 10'h100;
    localparam logic [MOTOR_W-1:0]   ROOT_MAX    = 10'h3ff;
    localparam logic [MOTOR_W-1:0]   PANIC_LEVEL = 10'h100;
    localparam logic [MOTOR_W-1:0]   STEP_RESET  = 10'd100;

    typedef enum logic [2:0] {
        MODE_SAFE    = 3'd0,
        MODE_PANIC   = 3'd1,
        MODE_CALIB   = 3'd2,
        MODE_MANUAL  = 3'd3,
        MODE_YAW     = 3'd4,
        MODE_FULL    = 3'd5
    } mode_t;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [THR_W-1:0] throttle_0;
        logic signed [THR_W-1:0] throttle_1;
        logic signed [THR_W-1:0] throttle_2;
        logic signed [THR_W-1:0] throttle_3;
    } in_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_0;
        logic [MOTOR_W-1:0] motor_1;
        logic [MOTOR_W-1:0] motor_2;
        logic [MOTOR_W-1:0] motor_3;
    } out_t;

    typedef struct packed {
        logic               done;
        logic [MOTOR_W-1:0] root;
    } lane_res_t;

    typedef enum logic [6:0] {
        LS_IDLE   = 7'b0000001,
        LS_COEF   = 7'b0000010,
        LS_PROD   = 7'b0000100,
        LS_EST    = 7'b0001000,
        LS_SQ     = 7'b0010000,
        LS_LAUNCH = 7'b0100000,
        LS_WAIT   = 7'b1000000
    } lane_state_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_HOLD = 3'b100
    } ctrl_state_t;

endpackage

>>> sv/mcs_div.sv
// ----------------------------------------------------------------------------
// Motor command shaper divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcs_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [mcs_pkg::DIV_NUM_W-1:0]  num,
    input  logic [mcs_pkg::DIV_DEN_W-1:0]  den,
    output logic                           done,
    output logic [mcs_pkg::DIV_NUM_W-1:0]  quo
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [mcs_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [mcs_pkg::DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [mcs_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [mcs_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [mcs_pkg::DIV_DEN_W:0]   rem_shift;
    logic [mcs_pkg::DIV_DEN_W:0]   rem_diff;

    assign rem_shift = {rem_reg, quo_reg[mcs_pkg::DIV_NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = mcs_pkg::DIV_CNT_W'(mcs_pkg::DIV_NUM_W - 1);
            quo_next  = num;
            den_next  = den;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, den_reg}) begin
                rem_next = rem_diff[mcs_pkg::DIV_DEN_W-1:0];
                quo_next = {quo_reg[mcs_pkg::DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[mcs_pkg::DIV_DEN_W-1:0];
                quo_next = {quo_reg[mcs_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> sv/mcs_lane.sv
// ----------------------------------------------------------------------------
// Motor command shaper lane
// Clamps one throttle and takes its Q10 square root with a quadratic
// estimate and one Newton step, then clamps the root to the drive range.
// ----------------------------------------------------------------------------
module mcs_lane (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [mcs_pkg::THR_W-1:0] throttle,
    output mcs_pkg::lane_res_t               res
);

    mcs_pkg::lane_state_t state_reg, state_next;

    logic [mcs_pkg::X_W-1:0]       x_reg, x_next;
    logic [20:0]                   a_reg, a_next;
    logic [29:0]                   p_reg, p_next;
    logic [9:0]                    e_reg, e_next;
    logic [9:0]                    sq_reg, sq_next;
    logic                          neg_reg, neg_next;
    logic [mcs_pkg::MOTOR_W-1:0]   root_reg, root_next;
    logic                          done_reg, done_next;

    logic [mcs_pkg::X_W-1:0]       x_clamp;
    logic [31:0]                   prod_ax;
    logic [20:0]                   est_sum;
    logic [19:0]                   prod_ee;
    logic signed [11:0]            diff;
    logic [10:0]                   diff_mag;
    logic                          div_start;
    logic                          div_done;
    logic [mcs_pkg::DIV_NUM_W-1:0] div_quo;
    logic signed [22:0]            quo_s;
    logic signed [22:0]            root_s;

    always_comb begin
        if (throttle < $signed({5'b0, mcs_pkg::THR_MIN})) begin
            x_clamp = mcs_pkg::THR_MIN;
        end else if (throttle > $signed({5'b0, mcs_pkg::THR_MAX})) begin
            x_clamp = mcs_pkg::THR_MAX;
        end else begin
            x_clamp = throttle[mcs_pkg::X_W-1:0];
        end
    end

    assign prod_ax  = a_reg * x_reg;
    assign est_sum  = {1'b0, p_reg[29:10]} + mcs_pkg::EST_C2;
    assign prod_ee  = e_reg * e_reg;
    assign diff     = $signed({2'b0, sq_reg}) - $signed({1'b0, x_reg});
    assign diff_mag = diff[11] ? 11'(-diff) : diff[10:0];
    assign div_start = (state_reg == mcs_pkg::LS_LAUNCH);

    assign quo_s  = neg_reg ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
    assign root_s = $signed({13'b0, e_reg}) - quo_s;

    mcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({diff_mag, 10'b0}),
        .den     ({e_reg, 1'b0}),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        a_next     = a_reg;
        p_next     = p_reg;
        e_next     = e_reg;
        sq_next    = sq_reg;
        neg_next   = neg_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            mcs_pkg::LS_IDLE: begin
                if (start) begin
                    x_next     = x_clamp;
                    state_next = mcs_pkg::LS_COEF;
                end
            end
            mcs_pkg::LS_COEF: begin
                a_next     = mcs_pkg::EST_C0 - ({11'b0, mcs_pkg::EST_C1} * {10'b0, x_reg});
                state_next = mcs_pkg::LS_PROD;
            end
            mcs_pkg::LS_PROD: begin
                p_next     = prod_ax[29:0];
                state_next = mcs_pkg::LS_EST;
            end
            mcs_pkg::LS_EST: begin
                e_next     = est_sum[19:10];
                state_next = mcs_pkg::LS_SQ;
            end
            mcs_pkg::LS_SQ: begin
                sq_next    = prod_ee[19:10];
                state_next = mcs_pkg::LS_LAUNCH;
            end
            mcs_pkg::LS_LAUNCH: begin
                neg_next   = diff[11];
                state_next = mcs_pkg::LS_WAIT;
            end
            mcs_pkg::LS_WAIT: begin
                if (div_done) begin
                    if (root_s < $signed({13'b0, mcs_pkg::ROOT_MIN})) begin
                        root_next = mcs_pkg::ROOT_MIN;
                    end else if (root_s > $signed({13'b0, mcs_pkg::ROOT_MAX})) begin
                        root_next = mcs_pkg::ROOT_MAX;
                    end else begin
                        root_next = root_s[mcs_pkg::MOTOR_W-1:0];
                    end
                    done_next  = 1'b1;
                    state_next = mcs_pkg::LS_IDLE;
                end
            end
            default: begin
                state_next = mcs_pkg::LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcs_pkg::LS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        x_reg    <= x_next;
        a_reg    <= a_next;
        p_reg    <= p_next;
        e_reg    <= e_next;
        sq_reg   <= sq_next;
        neg_reg  <= neg_next;
        root_reg <= root_next;
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule

>>> sv/motor_command_shaper_core.sv
// ----------------------------------------------------------------------------
// Motor command shaper core
// Four square-root lanes shape the throttles of one transaction in parallel;
// a merging stage applies the flight mode and the rise limit, keeps the
// previous drive values and holds the result in an output register.
// ----------------------------------------------------------------------------
// Channel  | Signals                         | Payload
// input    | s_valid, s_ready, s_data        | mcs_pkg::in_t (mode, throttle_0..3)
// result   | m_valid, m_ready, m_data        | mcs_pkg::out_t (motor_0..3)
// config   | cfg_we, cfg_wdata               | max_step, 10 bits
//
// After acceptance, a transaction's result becomes valid once every lane has
// finished its Newton step, which waits on the divider in that lane.
// A new transaction is accepted from the cycle after a result enters the
// output register, also while that result still waits on m_ready; a
// finished result then waits in the lanes until the output register frees up.
// Reset clears the previous drive values to zero and max_step to 100.
// ----------------------------------------------------------------------------
module motor_command_shaper_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  mcs_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output mcs_pkg::out_t                m_data,
    input  logic                         cfg_we,
    input  logic [mcs_pkg::MOTOR_W-1:0]  cfg_wdata
);

    mcs_pkg::ctrl_state_t state_reg, state_next;

    logic [mcs_pkg::MOTOR_W-1:0] max_step_reg;
    logic [mcs_pkg::MOTOR_W-1:0] prev_reg [mcs_pkg::NUM_MOTORS];
    logic [mcs_pkg::MOTOR_W-1:0] res_val  [mcs_pkg::NUM_MOTORS];
    logic [2:0]                  mode_reg;
    logic                        zero_reg;
    logic                        m_valid_reg, m_valid_next;
    mcs_pkg::out_t               m_data_reg;

    logic signed [mcs_pkg::THR_W-1:0] thr [mcs_pkg::NUM_MOTORS];
    mcs_pkg::lane_res_t          lane_res [mcs_pkg::NUM_MOTORS];
    logic [mcs_pkg::NUM_MOTORS-1:0] lane_done;
    logic                        accept;
    logic                        out_free;
    logic                        load;
    logic                        flying;

    assign thr[0] = s_data.throttle_0;
    assign thr[1] = s_data.throttle_1;
    assign thr[2] = s_data.throttle_2;
    assign thr[3] = s_data.throttle_3;

    assign s_ready  = (state_reg == mcs_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    genvar g;
    generate
        for (g = 0; g < mcs_pkg::NUM_MOTORS; g++) begin : g_lane
            mcs_lane u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .start    (accept),
                .throttle (thr[g]),
                .res      (lane_res[g])
            );
            assign lane_done[g] = lane_res[g].done;
        end
    endgenerate

    assign flying = (mode_reg == mcs_pkg::MODE_MANUAL) || (mode_reg == mcs_pkg::MODE_YAW) ||
                    (mode_reg == mcs_pkg::MODE_FULL);

    always_comb begin
        logic [mcs_pkg::MOTOR_W:0] limit;
        for (int i = 0; i < mcs_pkg::NUM_MOTORS; i++) begin
            limit = {1'b0, prev_reg[i]} + {1'b0, max_step_reg};
            if (mode_reg == mcs_pkg::MODE_PANIC) begin
                res_val[i] = zero_reg ? '0 : mcs_pkg::PANIC_LEVEL;
            end else if (flying && !zero_reg) begin
                if ({1'b0, lane_res[i].root} > limit) begin
                    res_val[i] = limit[mcs_pkg::MOTOR_W-1:0];
                end else begin
                    res_val[i] = lane_res[i].root;
                end
            end else begin
                res_val[i] = '0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        load       = 1'b0;
        unique case (state_reg)
            mcs_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = mcs_pkg::ST_BUSY;
                end
            end
            mcs_pkg::ST_BUSY: begin
                if (&lane_done) begin
                    if (out_free) begin
                        load       = 1'b1;
                        state_next = mcs_pkg::ST_IDLE;
                    end else begin
                        state_next = mcs_pkg::ST_HOLD;
                    end
                end
            end
            mcs_pkg::ST_HOLD: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = mcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mcs_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            max_step_reg <= mcs_pkg::STEP_RESET;
            for (int i = 0; i < mcs_pkg::NUM_MOTORS; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                max_step_reg <= cfg_wdata;
            end
            if (load) begin
                for (int i = 0; i < mcs_pkg::NUM_MOTORS; i++) begin
                    prev_reg[i] <= res_val[i];
                end
            end
        end
        if (accept) begin
            mode_reg <= s_data.mode;
            zero_reg <= (s_data.throttle_0 == '0) && (s_data.throttle_1 == '0) &&
                        (s_data.throttle_2 == '0) && (s_data.throttle_3 == '0);
        end
        if (load) begin
            m_data_reg.motor_0 <= res_val[0];
            m_data_reg.motor_1 <= res_val[1];
            m_data_reg.motor_2 <= res_val[2];
            m_data_reg.motor_3 <= res_val[3];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Motor command shaper testbench
// Drives flight-mode and throttle transactions through the valid/ready input
// channel, predicts the four drive values of each transaction with its own
// square-root, clamp and rise-limit arithmetic, and compares each result in
// order. It uses random gaps, receiver stalls, a long receiver hold and
// max_step settings that include both extremes.
// ----------------------------------------------------------------------------
module tb;

    import mcs_pkg::*;

    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 800000;

    class drive_tracker;
        out_t               pending_drives[$];
        logic [MOTOR_W-1:0] max_step;
        logic [MOTOR_W-1:0] last_drive[NUM_MOTORS];
        int mismatches;
        int updates;
        int flying_updates;
        int panic_updates;
        int limited_lanes;
        int checked;

        function new();
            max_step = STEP_RESET;
            foreach (last_drive[i]) last_drive[i] = '0;
        endfunction

        function logic [MOTOR_W-1:0] shaped_root(int x);
            longint est;
            longint corr;
            est = (longint'(int'(EST_C0) - int'(EST_C1) * x) * x) >>> 10;
            est = (est + int'(EST_C2)) >>> 10;
            if (est < 1) est = 1;
            corr = ((((est * est) >>> 10) - x) * 1024) / (2 * est);
            est = est - corr;
            if (est > longint'(ROOT_MAX)) est = ROOT_MAX;
            else if (est < longint'(ROOT_MIN)) est = ROOT_MIN;
            return est[MOTOR_W-1:0];
        endfunction

        function void note_update(in_t u);
            logic signed [THR_W-1:0] thr[NUM_MOTORS];
            logic [MOTOR_W-1:0]      drive[NUM_MOTORS];
            bit zero_set;
            int x;
            int cap;
            thr[0] = u.throttle_0;
            thr[1] = u.throttle_1;
            thr[2] = u.throttle_2;
            thr[3] = u.throttle_3;
            zero_set = 1'b1;
            foreach (thr[i]) begin
                if (thr[i] != 0) zero_set = 1'b0;
                drive[i] = '0;
            end
            updates++;
            if (u.mode == MODE_PANIC) begin
                panic_updates++;
                if (!zero_set) begin
                    foreach (drive[i]) drive[i] = PANIC_LEVEL;
                end
            end else if ((u.mode == MODE_MANUAL || u.mode == MODE_YAW
                          || u.mode == MODE_FULL) && !zero_set) begin
                flying_updates++;
                foreach (thr[i]) begin
                    x = int'(thr[i]);
                    if (x < int'(THR_MIN)) x = THR_MIN;
                    else if (x > int'(THR_MAX)) x = THR_MAX;
                    drive[i] = shaped_root(x);
                    cap = int'(last_drive[i]) + int'(max_step);
                    if (int'(drive[i]) > cap) begin
                        drive[i] = cap[MOTOR_W-1:0];
                        limited_lanes++;
                    end
                end
            end
            last_drive = drive;
            pending_drives.push_back(out_t'{drive[0], drive[1], drive[2], drive[3]});
        endfunction

        function void check_drive(out_t got);
            out_t want;
            bit   bad;
            if (pending_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d %0d %0d %0d with nothing pending",
                             got.motor_0, got.motor_1, got.motor_2, got.motor_3);
                return;
            end
            want = pending_drives.pop_front();
            checked++;
            bad = (got.motor_0 !== want.motor_0) || (got.motor_1 !== want.motor_1)
                  || (got.motor_2 !== want.motor_2) || (got.motor_3 !== want.motor_3);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                             checked, want.motor_0, want.motor_1, want.motor_2,
                             want.motor_3, got.motor_0, got.motor_1, got.motor_2,
                             got.motor_3);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_t                s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_t               m_data;
    logic               cfg_we = 1'b0;
    logic [MOTOR_W-1:0] cfg_wdata = '0;

    drive_tracker tracker = new();
    int  cycles;
    int  ready_left;
    bit  hold_request;
    int  holds_done;
    int  input_stalls;
    int  step_settings;

    motor_command_shaper_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_drive(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_left = 0;
        end else if (hold_request) begin
            m_ready <= 1'b0;
            ready_left = HOLD_CYCLES - 1;
            hold_request = 1'b0;
            holds_done++;
        end else if (ready_left != 0) begin
            ready_left--;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            ready_left = ($urandom_range(0, 99) < 4) ? $urandom_range(40, 150)
                                                      : $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
            ready_left = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 7);
        end
    end

    function automatic in_t make_update(logic [2:0] mode, int a, int b, int c, int d);
        in_t u;
        u.mode       = mode;
        u.throttle_0 = 16'(a);
        u.throttle_1 = 16'(b);
        u.throttle_2 = 16'(c);
        u.throttle_3 = 16'(d);
        return u;
    endfunction

    function automatic int random_throttle();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return $urandom_range(0, 1100);
        if (p < 70) begin
            case ($urandom_range(0, 5))
                0: return 62;
                1: return 63;
                2: return 64;
                3: return 1023;
                4: return 1024;
                default: return 1025;
            endcase
        end
        if (p < 80) return -int'($urandom_range(1, 2000));
        return int'($urandom_range(0, 65535));
    endfunction

    function automatic in_t random_update();
        int p;
        logic [2:0] mode;
        p = $urandom_range(0, 99);
        if (p < 70) begin
            case ($urandom_range(0, 2))
                0: mode = MODE_MANUAL;
                1: mode = MODE_YAW;
                default: mode = MODE_FULL;
            endcase
        end else if (p < 80) begin
            mode = MODE_PANIC;
        end else if (p < 92) begin
            case ($urandom_range(0, 3))
                0: mode = MODE_SAFE;
                1: mode = MODE_CALIB;
                2: mode = MODE_RSVD6;
                default: mode = MODE_RSVD7;
            endcase
        end else begin
            mode = 3'($urandom_range(0, 7));
            return make_update(mode, 0, 0, 0, 0);
        end
        return make_update(mode, random_throttle(), random_throttle(),
                           random_throttle(), random_throttle());
    endfunction

    task automatic send_update(in_t u);
        int p;
        int gap;
        s_data  <= u;
        s_valid <= 1'b1;
        do begin
            @(posedge aclk);
            if (!s_ready) input_stalls++;
        end while (!s_ready);
        tracker.note_update(u);
        p = $urandom_range(0, 99);
        gap = (p < 60) ? 0 : (p < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (tracker.pending_drives.size() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(int count);
        repeat (count) send_update(random_update());
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_max_step(logic [MOTOR_W-1:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.max_step = value;
        step_settings++;
        @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_update(make_update(MODE_SAFE, 500, 500, 500, 500));
        send_update(make_update(MODE_MANUAL, 1024, 1024, 1024, 1024));
        send_update(make_update(MODE_MANUAL, 1024, 1024, 1024, 1024));
        send_update(make_update(MODE_YAW, 32767, -32768, 0, 63));
        send_update(make_update(MODE_FULL, 62, 64, 1023, 1025));
        send_update(make_update(MODE_FULL, -1, 'h7fff, 'h8000, 1));
        send_update(make_update(MODE_CALIB, 300, 300, 300, 300));
        send_update(make_update(MODE_PANIC, 0, 0, 0, 0));
        send_update(make_update(MODE_PANIC, 1, 0, 0, 0));
        send_update(make_update(MODE_MANUAL, 0, 0, 0, 0));
        send_update(make_update(MODE_RSVD6, 700, 700, 700, 700));
        send_update(make_update(MODE_RSVD7, 'hffff, 'hffff, 'hffff, 'hffff));
        send_update(make_update(MODE_PANIC, -32768, -32768, -32768, -32768));
        send_update(make_update(MODE_FULL, 63, 63, 63, 63));
        send_update(make_update(MODE_MANUAL, 1024, 1024, 1024, 1024));
        send_update(make_update(MODE_YAW, 512, 256, 128, 800));
        send_update(make_update(MODE_FULL, 1024, 1024, 1024, 1024));
        send_update(make_update(MODE_MANUAL, 100, 200, 300, 400));
        send_update(make_update(MODE_YAW, 0, 0, 0, 5));
        send_update(make_update(MODE_RSVD7, 0, 0, 0, 0));
        send_update(make_update(MODE_PANIC, 300, -5, 'h5555, 'haaaa));
        send_update(make_update(MODE_FULL, 'h5555, 'haaaa, 'h7fff, 'h8001));
        s_valid <= 1'b0;
        @(posedge aclk);

        write_max_step(10'd0);
        run_phase(110);
        write_max_step(10'd1023);
        run_phase(60);
        hold_request = 1'b1;
        run_phase(60);
        write_max_step(10'd1);
        run_phase(50);
        wait_drained();
        run_phase(60);
        write_max_step(10'd512);
        run_phase(130);
        write_max_step(10'($urandom_range(2, 1022)));
        run_phase(130);
        write_max_step(STEP_RESET);
        run_phase(130);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d of %0d updates over %0d max_step settings: %0d flying, %0d panic.",
                 tracker.checked, tracker.updates, step_settings + 1,
                 tracker.flying_updates, tracker.panic_updates);
        $display("Rise limit engaged on %0d lanes; %0d input stall cycles, %0d long holds.",
                 tracker.limited_lanes, input_stalls, holds_done);
        if (tracker.mismatches == 0 && tracker.pending_drives.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/mcs_pkg.sv
sv/mcs_div.sv
sv/mcs_lane.sv
sv/motor_command_shaper_core.sv
test/tb.sv
